FILE: rtl/asw_pkg.sv
// ----------------------------------------------------------------------------
// asw_pkg: shared types and constants of the activity stall watchdog
// Event codes, configuration register indexes, clamp limits and the
// configuration bundle passed from the register file to the datapath.
// ----------------------------------------------------------------------------
package asw_pkg;

  // Time base width of all timestamps and elapsed-time arithmetic
  localparam int unsigned TIME_W = 32;

  // Field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LEVEL_W  = 14;
  localparam int unsigned THR_W    = 13;
  localparam int unsigned INTV_W   = 12;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned MIN_W    = 8;
  localparam int unsigned COOL_W   = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Derived millisecond widths: 3600 s * 1000 and 255 min * 60000 fit here
  localparam int unsigned INTV_MS_W  = 22;
  localparam int unsigned STALL_MS_W = 24;

  // Event codes
  localparam logic [KIND_W-1:0] KIND_POLL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_N   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd5;

  // Clamp limits
  localparam logic [INTV_W-1:0] INTV_MIN = 12'd10;
  localparam logic [INTV_W-1:0] INTV_MAX = 12'd3600;
  localparam logic [THR_W-1:0]  THR_MIN  = 13'd100;
  localparam logic [THR_W-1:0]  THR_MAX  = 13'd5000;

  // Unit conversions
  localparam logic [INTV_MS_W-1:0]  MS_PER_SEC = 22'd1000;
  localparam logic [STALL_MS_W-1:0] MS_PER_MIN = 24'd60000;

  // Reset values
  localparam logic [INTV_MS_W-1:0]  RST_INTV_MS  = 22'd60000;
  localparam logic [THR_W-1:0]      RST_THR      = 13'd500;
  localparam logic                  RST_MODE     = 1'b1;
  localparam logic [COUNT_W-1:0]    RST_FORCE_N  = 8'd0;
  localparam logic [STALL_MS_W-1:0] RST_STALL_MS = 24'd600000;
  localparam logic [COOL_W-1:0]     RST_COOL     = 20'd30000;

  // Configuration bundle, times already in milliseconds
  typedef struct packed {
    logic [INTV_MS_W-1:0]  interval_ms;
    logic [THR_W-1:0]      threshold;
    logic                  motion_only;
    logic [COUNT_W-1:0]    force_n;
    logic [STALL_MS_W-1:0] stall_ms;
    logic [COOL_W-1:0]     cooldown_ms;
  } cfg_t;

endpackage

FILE: rtl/activity_stall_watchdog.sv
// ----------------------------------------------------------------------------
// activity_stall_watchdog: motion check, stall alert and photo scheduling
// Evaluates poll, enable and disable events against the watchdog state
// and reports check, motion, stall alert and photo decisions per event.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | role
//  ----------+------------------------------------------------+----------------
//  in        | in_valid_i/in_ready_o, kind, now_ms, level,    | event beat
//            | capture_ok                                     |
//  out       | out_valid_o/out_ready_i, check_done ... level  | result beat
//  cfg       | cfg_we_i, cfg_idx_i, cfg_wdata_i               | register write
//
//  One event per cycle sustained while the result side is not stalled;
//  the result beat becomes valid once its event beat has passed the input
//  register and then the result register, which loads when it can advance.
//  The single evaluation stage between the two registers sets the rate:
//  three time subtractions and compares against the state registers.
//  Reset clears the state and loads the register defaults; no clear pass.
//  A stalled result holds its register; the input register keeps
//  accepting as long as it is empty or the result register can advance.
// ----------------------------------------------------------------------------
module activity_stall_watchdog
  import asw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // event channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic [LEVEL_W-1:0]   motion_level_i,
  input  logic                 capture_ok_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 check_done_o,
  output logic                 motion_seen_o,
  output logic                 stall_alert_o,
  output logic                 photo_sent_o,
  output logic                 photo_is_stall_o,
  output logic [LEVEL_W-1:0]   last_level_o
);

  cfg_t cfg;

  asw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register
  logic                in_vld_q;
  logic [KIND_W-1:0]   kind_q;
  logic [TIME_W-1:0]   now_q;
  logic [LEVEL_W-1:0]  lvl_q;
  logic                cap_q;

  // Watchdog state
  logic                enabled_d, enabled_q;
  logic [TIME_W-1:0]   last_check_d, last_check_q;
  logic [TIME_W-1:0]   last_motion_d, last_motion_q;
  logic [TIME_W-1:0]   last_photo_d, last_photo_q;
  logic [COUNT_W-1:0]  quiet_d, quiet_q;
  logic                stall_rep_d, stall_rep_q;
  logic [LEVEL_W-1:0]  level_d, level_q;

  // Result register
  logic                out_vld_q;
  logic                chk_d, chk_q;
  logic                mot_d, mot_q;
  logic                alert_d, alert_q;
  logic                sent_d, sent_q;
  logic                is_stall_d, is_stall_q;

  logic                adv;
  logic                in_acc;
  logic [TIME_W-1:0]   chk_elapsed, mot_elapsed, pho_elapsed;
  logic                due, motion, stall_hit, photo_ok, force_hit;
  logic [COUNT_W-1:0]  quiet_inc;

  // Handshake: result register advances when empty or taken
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Elapsed times wrap modulo the time base
  assign chk_elapsed = now_q - last_check_q;
  assign mot_elapsed = now_q - last_motion_q;
  assign pho_elapsed = now_q - last_photo_q;

  assign due       = chk_elapsed >= TIME_W'(cfg.interval_ms);
  assign motion    = lvl_q >= LEVEL_W'(cfg.threshold);
  // a motion hit restarts the stall timer, so it never alerts on that check
  assign stall_hit = !motion && !stall_rep_q && (mot_elapsed > TIME_W'(cfg.stall_ms));
  assign photo_ok  = (pho_elapsed >= TIME_W'(cfg.cooldown_ms)) && cap_q;
  assign quiet_inc = quiet_q + COUNT_W'(1);
  assign force_hit = (cfg.force_n != '0) && (quiet_inc >= cfg.force_n);

  // Evaluate the held event against the state
  always_comb begin
    enabled_d     = enabled_q;
    last_check_d  = last_check_q;
    last_motion_d = last_motion_q;
    last_photo_d  = last_photo_q;
    quiet_d       = quiet_q;
    stall_rep_d   = stall_rep_q;
    level_d       = level_q;
    chk_d         = 1'b0;
    mot_d         = 1'b0;
    alert_d       = 1'b0;
    sent_d        = 1'b0;
    is_stall_d    = 1'b0;
    if (in_vld_q && adv) begin
      unique case (kind_q)
        KIND_ENABLE: begin
          enabled_d     = 1'b1;
          stall_rep_d   = 1'b0;
          last_check_d  = '0;
          quiet_d       = '0;
          last_motion_d = now_q;
        end
        KIND_DISABLE: begin
          enabled_d    = 1'b0;
          stall_rep_d  = 1'b0;
          last_check_d = '0;
          quiet_d      = '0;
        end
        KIND_POLL: begin
          if (enabled_q && due) begin
            chk_d        = 1'b1;
            mot_d        = motion;
            last_check_d = now_q;
            level_d      = lvl_q;
            if (motion) begin
              last_motion_d = now_q;
              stall_rep_d   = 1'b0;
            end
            if (stall_hit) begin
              // one-shot alert with a stall photo attempt
              stall_rep_d = 1'b1;
              alert_d     = 1'b1;
              sent_d      = photo_ok;
              is_stall_d  = photo_ok;
            end else if (cfg.motion_only && !motion) begin
              // quiet check: count toward a forced photo
              quiet_d = force_hit ? '0 : quiet_inc;
              sent_d  = force_hit && photo_ok;
            end else begin
              sent_d = photo_ok;
            end
            if (sent_d) begin
              last_photo_d = now_q;
            end
          end
        end
        default: begin
          // unknown event: no state change
          enabled_d = enabled_q;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      enabled_q     <= 1'b0;
      last_check_q  <= '0;
      last_motion_q <= '0;
      last_photo_q  <= '0;
      quiet_q       <= '0;
      stall_rep_q   <= 1'b0;
      level_q       <= '0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      enabled_q     <= enabled_d;
      last_check_q  <= last_check_d;
      last_motion_q <= last_motion_d;
      last_photo_q  <= last_photo_d;
      quiet_q       <= quiet_d;
      stall_rep_q   <= stall_rep_d;
      level_q       <= level_d;
    end
  end

  // Capture the event beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      now_q  <= now_ms_i;
      lvl_q  <= motion_level_i;
      cap_q  <= capture_ok_i;
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (adv) begin
      chk_q      <= chk_d;
      mot_q      <= mot_d;
      alert_q    <= alert_d;
      sent_q     <= sent_d;
      is_stall_q <= is_stall_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign check_done_o     = chk_q;
  assign motion_seen_o    = mot_q;
  assign stall_alert_o    = alert_q;
  assign photo_sent_o     = sent_q;
  assign photo_is_stall_o = is_stall_q;
  assign last_level_o     = level_q;

endmodule

FILE: rtl/asw_cfg.sv
// ----------------------------------------------------------------------------
// asw_cfg: configuration registers of the activity stall watchdog
// Clamps the written interval and threshold and keeps the interval and
// stall time in milliseconds, so the datapath only subtracts and compares.
// ----------------------------------------------------------------------------
module asw_cfg
  import asw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t              cfg_d, cfg_q;
  logic [INTV_W-1:0] intv_raw, intv_clamp;
  logic [THR_W-1:0]  thr_raw, thr_clamp;

  // Clamp interval and threshold to their legal ranges
  always_comb begin
    intv_raw = cfg_wdata_i[INTV_W-1:0];
    thr_raw  = cfg_wdata_i[THR_W-1:0];
    if (intv_raw < INTV_MIN) begin
      intv_clamp = INTV_MIN;
    end else if (intv_raw > INTV_MAX) begin
      intv_clamp = INTV_MAX;
    end else begin
      intv_clamp = intv_raw;
    end
    if (thr_raw < THR_MIN) begin
      thr_clamp = THR_MIN;
    end else if (thr_raw > THR_MAX) begin
      thr_clamp = THR_MAX;
    end else begin
      thr_clamp = thr_raw;
    end
  end

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INTERVAL:  cfg_d.interval_ms = INTV_MS_W'(intv_clamp) * MS_PER_SEC;
        REG_THRESHOLD: cfg_d.threshold   = thr_clamp;
        REG_MODE:      cfg_d.motion_only = cfg_wdata_i[0];
        REG_FORCE_N:   cfg_d.force_n     = cfg_wdata_i[COUNT_W-1:0];
        REG_STALL_MIN: cfg_d.stall_ms    =
                         STALL_MS_W'(cfg_wdata_i[MIN_W-1:0]) * MS_PER_MIN;
        REG_COOLDOWN:  cfg_d.cooldown_ms = cfg_wdata_i[COOL_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ms <= RST_INTV_MS;
      cfg_q.threshold   <= RST_THR;
      cfg_q.motion_only <= RST_MODE;
      cfg_q.force_n     <= RST_FORCE_N;
      cfg_q.stall_ms    <= RST_STALL_MS;
      cfg_q.cooldown_ms <= RST_COOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/asw_checker.sv
// ----------------------------------------------------------------------------
// asw_checker: port-level checks of the activity stall watchdog
// Watches the result channel for flag combinations the watchdog can
// never produce and for a held result beat.
// ----------------------------------------------------------------------------
module asw_checker
  import asw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                check_done_i,
  input  logic                motion_seen_i,
  input  logic                stall_alert_i,
  input  logic                photo_sent_i,
  input  logic                photo_is_stall_i,
  input  logic [LEVEL_W-1:0]  last_level_i
);

  // A stall photo comes only with a sent photo on an alert
  a_stall_photo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && photo_is_stall_i) |-> (photo_sent_i && stall_alert_i))
    else $error("stall photo without alert or send");

  // An alert means a check without motion
  a_alert_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && stall_alert_i) |-> (check_done_i && !motion_seen_i))
    else $error("stall alert outside a quiet check");

  // Photos and motion only come from a check
  a_check_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (photo_sent_i || motion_seen_i)) |-> check_done_i)
    else $error("photo or motion without a check");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(check_done_i) && $stable(photo_sent_i) &&
       $stable(last_level_i)))
    else $error("result beat changed while stalled");

endmodule

bind activity_stall_watchdog asw_checker u_asw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .check_done_i     (check_done_o),
  .motion_seen_i    (motion_seen_o),
  .stall_alert_i    (stall_alert_o),
  .photo_sent_i     (photo_sent_o),
  .photo_is_stall_i (photo_is_stall_o),
  .last_level_i     (last_level_o)
);

FILE: tb/asw_watchdog_monitor.sv
// ----------------------------------------------------------------------------
// asw_watchdog_monitor: result predictor and scoreboard of the watchdog
// Mirrors the register writes, predicts one verdict per accepted event beat
// and compares every accepted result beat with the oldest verdict waiting.
// ----------------------------------------------------------------------------
module asw_watchdog_monitor
  import asw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // register write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // event channel
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic [LEVEL_W-1:0]   motion_level_i,
  input  logic                 capture_ok_i,
  // result channel
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 check_done_i,
  input  logic                 motion_seen_i,
  input  logic                 stall_alert_i,
  input  logic                 photo_sent_i,
  input  logic                 photo_is_stall_i,
  input  logic [LEVEL_W-1:0]   last_level_i,
  // status towards the stimulus side
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  // Register defaults and write clamps
  localparam int unsigned DEF_INTERVAL_S = 60;
  localparam int unsigned DEF_THRESHOLD  = 500;
  localparam int unsigned DEF_STALL_LEN  = 10;
  localparam int unsigned DEF_COOLDOWN   = 30000;
  localparam int unsigned IVL_LO = 10;
  localparam int unsigned IVL_HI = 3600;
  localparam int unsigned THR_LO = 100;
  localparam int unsigned THR_HI = 5000;

  typedef struct packed {
    logic               check_done;
    logic               motion_seen;
    logic               stall_alert;
    logic               photo_sent;
    logic               photo_is_stall;
    logic [LEVEL_W-1:0] level;
  } verdict_t;

  // Register mirror
  logic [INTV_W-1:0]  m_interval;
  logic [THR_W-1:0]   m_threshold;
  logic               m_motion_only;
  logic [COUNT_W-1:0] m_force_n;
  logic [MIN_W-1:0]   m_stall_len;
  logic [COOL_W-1:0]  m_cooldown;

  // Watchdog state mirror
  logic               w_enabled;
  logic [TIME_W-1:0]  t_check;
  logic [TIME_W-1:0]  t_motion;
  logic [TIME_W-1:0]  t_photo;
  logic [COUNT_W-1:0] quiet_cnt;
  logic               stall_flag;
  logic [LEVEL_W-1:0] held_level;

  verdict_t    verdict_q[$];
  verdict_t    want_v;
  verdict_t    new_v;
  int unsigned fails = 0;

  assign fail_count_o = fails;

  // Clamp and store one register write
  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] data);
    int unsigned v;
    case (idx)
      REG_INTERVAL: begin
        v = data[INTV_W-1:0];
        if (v < IVL_LO) v = IVL_LO;
        if (v > IVL_HI) v = IVL_HI;
        m_interval = INTV_W'(v);
      end
      REG_THRESHOLD: begin
        v = data[THR_W-1:0];
        if (v < THR_LO) v = THR_LO;
        if (v > THR_HI) v = THR_HI;
        m_threshold = THR_W'(v);
      end
      REG_MODE:      m_motion_only = data[0];
      REG_FORCE_N:   m_force_n     = data[COUNT_W-1:0];
      REG_STALL_MIN: m_stall_len   = data[MIN_W-1:0];
      REG_COOLDOWN:  m_cooldown    = data[COOL_W-1:0];
      default: ;
    endcase
  endtask

  // Grant a photo when the cooldown is over and the capture works
  function automatic logic grant_photo(input logic [TIME_W-1:0] now, input logic cap_ok);
    logic [TIME_W-1:0] since;
    since = now - t_photo;
    if (since < m_cooldown || !cap_ok) return 1'b0;
    t_photo = now;
    return 1'b1;
  endfunction

  // Advance the state by one event and build its verdict
  task automatic predict_event(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                               input logic [LEVEL_W-1:0] level, input logic cap_ok,
                               output verdict_t v);
    logic [TIME_W-1:0] since_check;
    logic [TIME_W-1:0] since_motion;
    logic              want_photo;
    v = '0;
    case (kind)
      KIND_ENABLE, KIND_DISABLE: begin
        w_enabled  = (kind == KIND_ENABLE);
        stall_flag = 1'b0;
        t_check    = '0;
        quiet_cnt  = '0;
        if (kind == KIND_ENABLE) t_motion = now;
      end
      KIND_POLL: begin
        since_check = now - t_check;
        if (w_enabled && longint'(since_check) >= longint'(m_interval) * 1000) begin
          v.check_done  = 1'b1;
          t_check       = now;
          held_level    = level;
          v.motion_seen = (level >= m_threshold);
          if (v.motion_seen) begin
            t_motion   = now;
            stall_flag = 1'b0;
          end
          since_motion = now - t_motion;
          if (!stall_flag && longint'(since_motion) > longint'(m_stall_len) * 60000) begin
            // one-shot stall alert with its own photo attempt
            stall_flag       = 1'b1;
            v.stall_alert    = 1'b1;
            v.photo_sent     = grant_photo(now, cap_ok);
            v.photo_is_stall = v.photo_sent;
          end else begin
            want_photo = 1'b1;
            if (m_motion_only && !v.motion_seen) begin
              // count quiet checks, force a photo every Nth one
              quiet_cnt  = quiet_cnt + 1'b1;
              want_photo = 1'b0;
              if (m_force_n != 0 && quiet_cnt >= m_force_n) begin
                quiet_cnt  = '0;
                want_photo = 1'b1;
              end
            end
            if (want_photo) v.photo_sent = grant_photo(now, cap_ok);
          end
        end
      end
      default: ;
    endcase
    v.level = held_level;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Compare result beats, mirror writes, predict event beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_interval    = INTV_W'(DEF_INTERVAL_S);
      m_threshold   = THR_W'(DEF_THRESHOLD);
      m_motion_only = 1'b1;
      m_force_n     = '0;
      m_stall_len   = MIN_W'(DEF_STALL_LEN);
      m_cooldown    = COOL_W'(DEF_COOLDOWN);
      w_enabled     = 1'b0;
      t_check       = '0;
      t_motion      = '0;
      t_photo       = '0;
      quiet_cnt     = '0;
      stall_flag    = 1'b0;
      held_level    = '0;
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with no verdict waiting, actual level %0d",
                   $time, last_level_i);
          fails++;
        end else begin
          want_v = verdict_q.pop_front();
          check_field("check_done", want_v.check_done, check_done_i);
          check_field("motion_seen", want_v.motion_seen, motion_seen_i);
          check_field("stall_alert", want_v.stall_alert, stall_alert_i);
          check_field("photo_sent", want_v.photo_sent, photo_sent_i);
          check_field("photo_is_stall", want_v.photo_is_stall, photo_is_stall_i);
          check_field("last_level", want_v.level, last_level_i);
        end
      end
      if (cfg_we_i) apply_reg_write(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_i) begin
        predict_event(kind_i, now_ms_i, motion_level_i, capture_ok_i, new_v);
        verdict_q.push_back(new_v);
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

FILE: tb/activity_stall_watchdog_tb.sv
// ----------------------------------------------------------------------------
// activity_stall_watchdog_tb: stimulus and verdict for the stall watchdog
// Drives directed and random event beats over several register settings,
// with random idling on both channels; the monitor predicts and compares.
// ----------------------------------------------------------------------------
module activity_stall_watchdog_tb;
  import asw_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned STUCK_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 141;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i;
  logic [TIME_W-1:0]    now_ms_i;
  logic [LEVEL_W-1:0]   motion_level_i;
  logic                 capture_ok_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 check_done_o;
  logic                 motion_seen_o;
  logic                 stall_alert_o;
  logic                 photo_sent_o;
  logic                 photo_is_stall_o;
  logic [LEVEL_W-1:0]   last_level_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stuck_cycles = 0;
  bit          calm;

  // Stimulus shaping for the current setting
  int unsigned       cur_ivl_ms;
  int unsigned       cur_thr;
  int unsigned       cur_stall_ms;
  logic [TIME_W-1:0] tb_now;
  bit                tb_on;

  activity_stall_watchdog u_top (.*);

  asw_watchdog_monitor u_mon (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .now_ms_i         (now_ms_i),
    .motion_level_i   (motion_level_i),
    .capture_ok_i     (capture_ok_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .check_done_i     (check_done_o),
    .motion_seen_i    (motion_seen_o),
    .stall_alert_i    (stall_alert_o),
    .photo_sent_i     (photo_sent_o),
    .photo_is_stall_i (photo_is_stall_o),
    .last_level_i     (last_level_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Offer one event beat after random idle cycles and hold it until accepted
  task automatic send_event(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                            input logic [LEVEL_W-1:0] lv, input logic ok);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    now_ms_i       <= t;
    motion_level_i <= lv;
    capture_ok_i   <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every verdict has been matched
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Program all registers while idle; unused upper bits carry noise
  task automatic set_config(input logic [INTV_W-1:0] ivl, input logic [THR_W-1:0] thr,
                            input logic mode, input logic [COUNT_W-1:0] force_n,
                            input logic [MIN_W-1:0] stall_len, input logic [COOL_W-1:0] cool);
    int unsigned v;
    settle();
    write_reg(REG_INTERVAL, {8'($urandom), ivl});
    write_reg(REG_THRESHOLD, {7'($urandom), thr});
    write_reg(REG_MODE, {19'($urandom), mode});
    write_reg(REG_FORCE_N, {12'($urandom), force_n});
    write_reg(REG_STALL_MIN, {12'($urandom), stall_len});
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
    v = ivl;
    if (v < 10) v = 10;
    if (v > 3600) v = 3600;
    cur_ivl_ms = v * 1000;
    v = thr;
    if (v < 100) v = 100;
    if (v > 5000) v = 5000;
    cur_thr      = v;
    cur_stall_ms = stall_len * 60000;
  endtask

  // Mostly enabled polls with time stepping around the check interval
  task automatic run_phase(input int unsigned n_items);
    int unsigned       roll;
    logic [KIND_W-1:0] k;
    logic [LEVEL_W-1:0] lv;
    logic              ok;
    for (int unsigned i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (i == 0 || (!tb_on && roll < 70)) k = KIND_ENABLE;
      else if (roll < 3) k = KIND_DISABLE;
      else if (roll < 5) k = KIND_SPARE;
      else if (roll < 8) k = KIND_ENABLE;
      else k = KIND_POLL;

      roll = $urandom_range(0, 99);
      if (roll < 45) tb_now = tb_now + cur_ivl_ms + $urandom_range(0, 2000);
      else if (roll < 65) tb_now = tb_now + $urandom_range(0, cur_ivl_ms - 1);
      else if (roll < 80) tb_now = tb_now + cur_ivl_ms * $urandom_range(2, 6);
      else if (roll < 90) tb_now = tb_now + cur_stall_ms + $urandom_range(0, cur_ivl_ms);
      else if (roll < 95) tb_now = $urandom;

      roll = $urandom_range(0, 99);
      if (roll < 35) lv = LEVEL_W'($urandom_range(cur_thr, 16383));
      else if (roll < 50) lv = LEVEL_W'(cur_thr - $urandom_range(0, 1));
      else if (roll < 90) lv = LEVEL_W'($urandom_range(0, cur_thr - 1));
      else lv = LEVEL_W'($urandom);

      ok = ($urandom_range(0, 99) < 85);
      send_event(k, tb_now, lv, ok);
      if (k == KIND_ENABLE) tb_on = 1'b1;
      else if (k == KIND_DISABLE) tb_on = 1'b0;
    end
  endtask

  task automatic random_config();
    logic [COUNT_W-1:0] f;
    case ($urandom_range(0, 2))
      0: f = '0;
      1: f = COUNT_W'($urandom_range(1, 8));
      default: f = COUNT_W'($urandom);
    endcase
    set_config(INTV_W'($urandom_range(10, 3600)), THR_W'($urandom_range(100, 5000)),
               1'($urandom), f, MIN_W'($urandom), COOL_W'($urandom));
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_POLL;
    now_ms_i       = '0;
    motion_level_i = '0;
    capture_ok_i   = 1'b0;
    calm           = 1'b0;
    tb_now         = '0;
    tb_on          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short interval, one-minute stall, forced photo every 2nd quiet check
    set_config(12'd0, 13'd0, 1'b1, 8'd2, 8'd1, 20'd0);
    send_event(KIND_POLL, 32'd0, 14'h3FFF, 1'b1);
    send_event(KIND_SPARE, 32'hFFFF_FFFF, 14'h3FFF, 1'b1);
    send_event(KIND_ENABLE, 32'd1000, 14'd0, 1'b0);
    send_event(KIND_POLL, 32'd5000, 14'h3FFF, 1'b1);
    send_event(KIND_POLL, 32'd20000, 14'h3FFF, 1'b1);
    send_event(KIND_POLL, 32'd30000, 14'd99, 1'b1);
    send_event(KIND_POLL, 32'd40000, 14'd0, 1'b0);
    send_event(KIND_POLL, 32'd50000, 14'd100, 1'b1);
    send_event(KIND_POLL, 32'd60000, 14'd0, 1'b1);
    send_event(KIND_POLL, 32'd120001, 14'd0, 1'b1);
    send_event(KIND_POLL, 32'd130001, 14'd0, 1'b1);
    send_event(KIND_DISABLE, 32'd140000, 14'd10000, 1'b1);
    send_event(KIND_POLL, 32'd150000, 14'd10000, 1'b1);
    // time wrapping past the top of the counter
    send_event(KIND_ENABLE, 32'hFFFF_F000, 14'd0, 1'b1);
    send_event(KIND_POLL, 32'hFFFF_FFFF, 14'd10000, 1'b1);
    send_event(KIND_POLL, 32'h0000_2000, 14'd0, 1'b1);
    send_event(KIND_POLL, 32'h0000_3000, 14'd5000, 1'b1);

    // Directed: clamped maxima, every-check photos, stall time zero, long cooldown
    set_config(12'hFFF, 13'h1FFF, 1'b0, 8'hFF, 8'd0, 20'hFFFFF);
    send_event(KIND_ENABLE, 32'd1048576, 14'd0, 1'b1);
    send_event(KIND_POLL, 32'd4648576, 14'd4999, 1'b1);
    send_event(KIND_POLL, 32'd8248576, 14'd5000, 1'b1);
    send_event(KIND_POLL, 32'd11848575, 14'd5000, 1'b1);
    send_event(KIND_POLL, 32'd11848576, 14'd0, 1'b0);

    // Random phases over several settings
    tb_now = 32'd11848576;
    set_config(12'd60, 13'd500, 1'b1, 8'd0, 8'd10, 20'd30000);
    run_phase(PHASE_ITEMS);
    set_config(12'd10, 13'd100, 1'b1, 8'd1, 8'd1, 20'd0);
    run_phase(PHASE_ITEMS);
    set_config(12'd3600, 13'd5000, 1'b0, 8'd255, 8'd255, 20'd600000);
    run_phase(PHASE_ITEMS);
    // hold both sides busy for a whole phase
    set_config(12'd10, 13'd2000, 1'b1, 8'd3, 8'd2, 20'd15000);
    calm = 1'b1;
    run_phase(PHASE_ITEMS);
    calm = 1'b0;
    random_config();
    run_phase(PHASE_ITEMS);
    set_config(12'd30, 13'd800, 1'b0, 8'd0, 8'd0, 20'hFFFFF);
    run_phase(PHASE_ITEMS);
    set_config(12'd0, 13'h1FFF, 1'b1, 8'd255, 8'd1, 20'd0);
    run_phase(PHASE_ITEMS);
    random_config();
    run_phase(PHASE_ITEMS);

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
